// ----- rtl/core/csvm_pkg.sv -----
// Shared types, codes and constants for the coroutine stack machine.
`default_nettype none
package csvm_pkg;

  localparam int CONTEXTS_DEF    = 8;
  localparam int STACK_DEPTH_DEF = 256;
  localparam int LOCAL_COUNT_DEF = 16;
  localparam int CODE_DEPTH_DEF  = 256;

  localparam int ActionW = 2;
  localparam int IdW     = 3;
  localparam int AddrW   = 8;
  localparam int ByteW   = 8;
  localparam int LenW    = 9;
  localparam int StatusW = 4;
  localparam int WordW   = 32;

  typedef enum logic [ActionW-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_CREATE = 2'd1,
    ACT_EXEC   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 4'd0,
    ST_PRINTED   = 4'd1,
    ST_YIELDED   = 4'd2,
    ST_FINISHED  = 4'd3,
    ST_ALREADY   = 4'd4,
    ST_BAD_ID    = 4'd5,
    ST_BAD_OP    = 4'd6,
    ST_OVERFLOW  = 4'd7,
    ST_UNDERFLOW = 4'd8,
    ST_BAD_LOCAL = 4'd9,
    ST_TRUNC     = 4'd10,
    ST_FULL      = 4'd11,
    ST_CREATED   = 4'd12
  } status_t;

  typedef enum logic [1:0] {
    RS_READY     = 2'd0,
    RS_RUNNING   = 2'd1,
    RS_SUSPENDED = 2'd2,
    RS_DONE      = 2'd3
  } run_state_t;

  localparam logic [7:0] OP_PUSH  = 8'd0;
  localparam logic [7:0] OP_POP   = 8'd1;
  localparam logic [7:0] OP_ADD   = 8'd2;
  localparam logic [7:0] OP_SUB   = 8'd3;
  localparam logic [7:0] OP_EMIT  = 8'd4;
  localparam logic [7:0] OP_PAUSE = 8'd5;
  localparam logic [7:0] OP_CALL  = 8'd6;
  localparam logic [7:0] OP_RET   = 8'd7;
  localparam logic [7:0] OP_HALT  = 8'd8;
  localparam logic [7:0] OP_JMP   = 8'd9;
  localparam logic [7:0] OP_JZ    = 8'd10;
  localparam logic [7:0] OP_LOAD  = 8'd11;
  localparam logic [7:0] OP_STLOC = 8'd12;

  // True for opcodes carrying a four-byte immediate.
  function automatic logic op_wide(input logic [7:0] op);
    return (op == OP_PUSH) || (op == OP_JMP) || (op == OP_JZ) ||
           (op == OP_LOAD) || (op == OP_STLOC);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/coroutine_stack_vm_step.sv -----
// Coroutine stack machine top level: context table, sequencer and memories.
//
// One item is taken at a time; the next one is taken in the cycle after the
// result has been transferred. A load, an unknown action, a create on a full
// table, an execute of an uncreated or finished context, or one that ends at
// the code end goes straight to the result; a create first sweeps the new
// context's locals to zero. An execute fetches the opcode, then reads one code
// byte per immediate byte and two stack words, each through a memory with a
// registered read port; a bad or truncated opcode ends after the opcode
// fetch. The result is held while it is stalled. Reset clears the context
// table only; no memory clearing pass is needed.
`default_nettype none
module coroutine_stack_vm_step #(
  parameter int CONTEXTS    = csvm_pkg::CONTEXTS_DEF,
  parameter int STACK_DEPTH = csvm_pkg::STACK_DEPTH_DEF,
  parameter int LOCAL_COUNT = csvm_pkg::LOCAL_COUNT_DEF,
  parameter int CODE_DEPTH  = csvm_pkg::CODE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [csvm_pkg::ActionW-1:0]  action,
  input  wire logic [csvm_pkg::IdW-1:0]      context_id,
  input  wire logic [csvm_pkg::AddrW-1:0]    code_address,
  input  wire logic [csvm_pkg::ByteW-1:0]    code_byte,
  input  wire logic [csvm_pkg::LenW-1:0]     code_length,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [csvm_pkg::StatusW-1:0]       status,
  output logic signed [csvm_pkg::WordW-1:0]  printed_value,
  output logic [csvm_pkg::IdW-1:0]           new_id
);
  import csvm_pkg::*;

  localparam int CtxW  = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int CntW  = $clog2(CONTEXTS + 1);
  localparam int CodeW = $clog2(CODE_DEPTH);
  localparam int PcW   = $clog2(CODE_DEPTH + 1);
  localparam int SpAW  = $clog2(STACK_DEPTH);
  localparam int SpW   = $clog2(STACK_DEPTH + 1);
  localparam int LocW  = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
  localparam int CmAW  = CtxW + CodeW;
  localparam int SmAW  = CtxW + SpAW;
  localparam int LmAW  = CtxW + LocW;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_OP    = 9'b000000100,
    S_IMM   = 9'b000001000,
    S_POP1  = 9'b000010000,
    S_POP2  = 9'b000100000,
    S_LOC   = 9'b001000000,
    S_EXEC  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;

  // Context table.
  logic [PcW-1:0]  pc_tab  [CONTEXTS];
  logic [SpW-1:0]  sp_tab  [CONTEXTS];
  logic [PcW-1:0]  len_tab [CONTEXTS];
  run_state_t      rs_tab  [CONTEXTS];
  logic [CntW-1:0] ctx_count;

  // Working registers.
  logic [CtxW-1:0] ctx;
  logic [PcW-1:0]  pc, len;
  logic [SpW-1:0]  sp;
  logic [7:0]      op;
  logic [31:0]     imm, wa, wb;
  logic [2:0]      byte_idx;
  logic [LocW-1:0] clr_idx;

  // Memory ports.
  logic            cm_we;
  logic [CmAW-1:0] cm_waddr, cm_raddr;
  logic [7:0]      cm_rdata;
  logic            sm_we;
  logic [SmAW-1:0] sm_waddr, sm_raddr;
  logic [31:0]     sm_wdata, sm_rdata;
  logic            lm_we;
  logic [LmAW-1:0] lm_waddr, lm_raddr;
  logic [31:0]     lm_wdata, lm_rdata;

  csvm_code_mem #(.DEPTH(2 ** CmAW), .AW(CmAW)) u_code (
    .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(code_byte),
    .raddr(cm_raddr), .rdata(cm_rdata));
  csvm_word_mem #(.DEPTH(2 ** SmAW), .AW(SmAW)) u_stack (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .raddr(sm_raddr), .rdata(sm_rdata));
  csvm_word_mem #(.DEPTH(2 ** LmAW), .AW(LmAW)) u_locals (
    .clk(clk), .we(lm_we), .waddr(lm_waddr), .wdata(lm_wdata),
    .raddr(lm_raddr), .rdata(lm_rdata));

  logic in_xfer, out_xfer;
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Context index of the input item.
  logic [CtxW-1:0] in_ctx;
  assign in_ctx = CtxW'(context_id);

  // Decode helpers.
  logic        is_wide, op_bad, imm_big_local, target_big;
  logic [PcW-1:0] jump_pc;
  assign is_wide       = op_wide(op);
  assign op_bad        = (op > OP_STLOC) || (op == OP_CALL);
  assign imm_big_local = (imm >= 32'(LOCAL_COUNT));
  assign target_big    = (imm >= 32'(len));
  assign jump_pc       = target_big ? len : imm[PcW-1:0];

  // Code fetch address tracks pc plus the byte index.
  logic [PcW-1:0] fetch_pc;
  assign fetch_pc = pc + PcW'(byte_idx);
  assign cm_raddr = {ctx, fetch_pc[CodeW-1:0]};

  // Load writes the code store straight from the input.
  logic in_ctx_ok;
  assign in_ctx_ok = (32'(context_id) < 32'(CONTEXTS));
  assign cm_we    = in_xfer && (action == ACT_LOAD) && in_ctx_ok &&
                    (32'(code_address) < 32'(CODE_DEPTH));
  assign cm_waddr = {in_ctx, CodeW'(code_address)};

  // Stack and locals read addresses: top first, the word below it next.
  always_comb begin
    sm_raddr = {ctx, SpAW'(sp - SpW'(1))};
    if (state == S_POP1) begin
      sm_raddr = {ctx, SpAW'(sp - SpW'(2))};
    end
  end
  assign lm_raddr = {ctx, imm[LocW-1:0]};

  // Sequencer and state update.
  always_ff @(posedge clk) begin
    sm_we <= 1'b0;
    lm_we <= 1'b0;
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      ctx_count <= '0;
      for (int i = 0; i < CONTEXTS; i++) begin
        pc_tab[i]  <= '0;
        sp_tab[i]  <= '0;
        len_tab[i] <= '0;
        rs_tab[i]  <= RS_READY;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            status        <= ST_OK;
            printed_value <= '0;
            new_id        <= '0;
            ctx           <= in_ctx;
            state         <= S_OUT;
            case (action)
              ACT_LOAD: begin
                if (!in_ctx_ok) status <= ST_BAD_ID;
              end
              ACT_CREATE: begin
                if (ctx_count >= CntW'(CONTEXTS)) begin
                  status <= ST_FULL;
                end else begin
                  pc_tab[ctx_count[CtxW-1:0]] <= '0;
                  sp_tab[ctx_count[CtxW-1:0]] <= '0;
                  rs_tab[ctx_count[CtxW-1:0]] <= RS_READY;
                  len_tab[ctx_count[CtxW-1:0]] <=
                    (32'(code_length) > 32'(CODE_DEPTH)) ? PcW'(CODE_DEPTH)
                                                         : PcW'(code_length);
                  new_id    <= IdW'(ctx_count);
                  ctx       <= ctx_count[CtxW-1:0];
                  ctx_count <= ctx_count + CntW'(1);
                  status    <= ST_CREATED;
                  clr_idx   <= '0;
                  state     <= S_CLEAR;
                end
              end
              ACT_EXEC: begin
                if (32'(context_id) >= 32'(ctx_count)) begin
                  status <= ST_BAD_ID;
                end else if (rs_tab[in_ctx] == RS_DONE) begin
                  status <= ST_ALREADY;
                end else if (pc_tab[in_ctx] >= len_tab[in_ctx]) begin
                  rs_tab[in_ctx] <= RS_DONE;
                  status <= ST_FINISHED;
                end else begin
                  pc       <= pc_tab[in_ctx];
                  sp       <= sp_tab[in_ctx];
                  len      <= len_tab[in_ctx];
                  byte_idx <= '0;
                  state    <= S_OP;
                end
              end
              default: ;
            endcase
          end
        end
        // Sweep this context's locals to zero.
        S_CLEAR: begin
          lm_we    <= 1'b1;
          lm_waddr <= {ctx, clr_idx};
          lm_wdata <= '0;
          clr_idx  <= clr_idx + LocW'(1);
          if (32'(clr_idx) == 32'(LOCAL_COUNT - 1)) state <= S_OUT;
        end
        // Issue the opcode byte read at byte index zero, then capture the opcode when it returns.
        S_OP: begin
          if (byte_idx == 3'd0) begin
            byte_idx <= 3'd1;
          end else begin
            op       <= cm_rdata;
            byte_idx <= 3'd2;
            state    <= S_IMM;
          end
        end
        // Gather immediate bytes, one per cycle, then pop operands; bad or short opcodes end.
        S_IMM: begin
          if (op_bad) begin
            rs_tab[ctx] <= RS_DONE;
            status      <= ST_BAD_OP;
            state       <= S_OUT;
          end else if (!is_wide) begin
            state <= S_POP1;
          end else if (32'(len - pc) < 32'd5) begin
            rs_tab[ctx] <= RS_DONE;
            status      <= ST_TRUNC;
            state       <= S_OUT;
          end else begin
            imm      <= {cm_rdata, imm[31:8]};
            byte_idx <= byte_idx + 3'd1;
            if (byte_idx == 3'd5) state <= S_POP1;
          end
        end
        // Stack top read lands here.
        S_POP1: begin
          wb    <= sm_rdata;
          state <= S_POP2;
        end
        S_POP2: begin
          wa    <= sm_rdata;
          state <= S_LOC;
        end
        S_LOC: state <= S_EXEC;
        S_EXEC: begin
          state       <= S_OUT;
          rs_tab[ctx] <= RS_RUNNING;
          pc_tab[ctx] <= pc + (is_wide ? PcW'(5) : PcW'(1));
          case (op)
            OP_PUSH, OP_LOAD: begin
              if (op == OP_LOAD && imm_big_local) begin
                rs_tab[ctx] <= RS_DONE; status <= ST_BAD_LOCAL;
                pc_tab[ctx] <= pc;
              end else if (32'(sp) >= 32'(STACK_DEPTH)) begin
                rs_tab[ctx] <= RS_DONE; status <= ST_OVERFLOW;
                pc_tab[ctx] <= pc;
              end else begin
                sm_we       <= 1'b1;
                sm_waddr    <= {ctx, sp[SpAW-1:0]};
                sm_wdata    <= (op == OP_PUSH) ? imm : lm_rdata;
                sp_tab[ctx] <= sp + SpW'(1);
              end
            end
            OP_POP, OP_EMIT, OP_JZ, OP_STLOC: begin
              if (op == OP_STLOC && imm_big_local) begin
                rs_tab[ctx] <= RS_DONE; status <= ST_BAD_LOCAL;
                pc_tab[ctx] <= pc;
              end else if (sp == '0) begin
                rs_tab[ctx] <= RS_DONE; status <= ST_UNDERFLOW;
                pc_tab[ctx] <= pc;
              end else begin
                sp_tab[ctx] <= sp - SpW'(1);
                if (op == OP_STLOC) begin
                  lm_we    <= 1'b1;
                  lm_waddr <= {ctx, imm[LocW-1:0]};
                  lm_wdata <= wb;
                end
                if (op == OP_JZ && wb == '0) pc_tab[ctx] <= jump_pc;
                if (op == OP_EMIT) begin
                  status        <= ST_PRINTED;
                  printed_value <= wb;
                end
              end
            end
            OP_ADD, OP_SUB: begin
              if (sp < SpW'(2)) begin
                rs_tab[ctx] <= RS_DONE; status <= ST_UNDERFLOW;
                pc_tab[ctx] <= pc;
              end else begin
                sm_we       <= 1'b1;
                sm_waddr    <= {ctx, SpAW'(sp - SpW'(2))};
                sm_wdata    <= (op == OP_ADD) ? wa + wb : wa - wb;
                sp_tab[ctx] <= sp - SpW'(1);
              end
            end
            OP_PAUSE: begin
              rs_tab[ctx] <= RS_SUSPENDED; status <= ST_YIELDED;
            end
            OP_RET, OP_HALT: begin
              rs_tab[ctx] <= RS_DONE; status <= ST_FINISHED;
            end
            OP_JMP: pc_tab[ctx] <= jump_pc;
            default: ;
          endcase
        end
        // Present the result until transferred.
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (out_xfer) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(ctx_count) <= 32'(CONTEXTS)) else $error("context count too large");
  a_out_in_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result outside output state");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(status))
    else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/csvm_code_mem.sv -----
// Code byte store for all contexts: one write port, one registered read port.
`default_nettype none
module csvm_code_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);
  logic [7:0] mem [DEPTH];

  // Write and read the byte array.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/csvm_word_mem.sv -----
// Word store (operand stacks or locals): one write port, one registered read port.
`default_nettype none
module csvm_word_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);
  logic [31:0] mem [DEPTH];

  // Write and read the word array.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- dv/tb_coroutine_stack_vm_step.sv -----
// Self-checking testbench for the coroutine stack machine step block.
`default_nettype none
module tb_coroutine_stack_vm_step;
  import csvm_pkg::*;

  typedef struct packed {
    logic [StatusW-1:0] st;
    logic [WordW-1:0]   pv;
    logic [IdW-1:0]     nid;
  } vm_result_t;

  // Scoreboard: keeps its own copy of every context and the pending results.
  class vm_scoreboard;
    logic [7:0]       code_mem [8][256];
    logic [WordW-1:0] stack_mem [8][256];
    logic [WordW-1:0] local_mem [8][16];
    int unsigned      pc_q [8];
    int unsigned      sp_q [8];
    int unsigned      len_q [8];
    run_state_t       state_q [8];
    int unsigned      made;
    vm_result_t       pending_q [$];
    int               mismatches;
    int               checked;

    function new();
      made = 0;
      mismatches = 0;
      checked = 0;
      for (int c = 0; c < 8; c++) begin
        pc_q[c] = 0;
        sp_q[c] = 0;
        len_q[c] = 0;
        state_q[c] = RS_READY;
        for (int k = 0; k < 16; k++) local_mem[c][k] = '0;
      end
    endfunction

    // Execute one instruction of context c.
    function status_t step_context(int c, output logic [WordW-1:0] shown);
      logic [7:0]       op;
      logic [WordW-1:0] imm, a, b;
      int unsigned      p, len, s;
      bit               wide;
      shown = '0;
      imm = '0;
      p = pc_q[c];
      len = len_q[c];
      s = sp_q[c];
      if (p >= len) begin
        state_q[c] = RS_DONE;
        return ST_FINISHED;
      end
      op = code_mem[c][p];
      if (op > OP_STLOC || op == OP_CALL) begin
        state_q[c] = RS_DONE;
        return ST_BAD_OP;
      end
      wide = (op == OP_PUSH) || (op == OP_JMP) || (op == OP_JZ) ||
             (op == OP_LOAD) || (op == OP_STLOC);
      if (wide) begin
        if (len - p < 5) begin
          state_q[c] = RS_DONE;
          return ST_TRUNC;
        end
        imm = {code_mem[c][p+4], code_mem[c][p+3], code_mem[c][p+2], code_mem[c][p+1]};
        p += 5;
      end else begin
        p += 1;
      end
      state_q[c] = RS_RUNNING;
      case (op)
        OP_PUSH, OP_LOAD: begin
          if (op == OP_LOAD && imm >= 16) begin
            state_q[c] = RS_DONE;
            return ST_BAD_LOCAL;
          end
          if (s >= 256) begin
            state_q[c] = RS_DONE;
            return ST_OVERFLOW;
          end
          stack_mem[c][s] = (op == OP_PUSH) ? imm : local_mem[c][imm[3:0]];
          s++;
        end
        OP_POP, OP_EMIT, OP_JZ, OP_STLOC: begin
          if (op == OP_STLOC && imm >= 16) begin
            state_q[c] = RS_DONE;
            return ST_BAD_LOCAL;
          end
          if (s == 0) begin
            state_q[c] = RS_DONE;
            return ST_UNDERFLOW;
          end
          s--;
          a = stack_mem[c][s];
          if (op == OP_STLOC) local_mem[c][imm[3:0]] = a;
          if (op == OP_JZ && a == 0) p = (imm >= len) ? len : imm;
          if (op == OP_EMIT) begin
            shown = a;
            pc_q[c] = p;
            sp_q[c] = s;
            return ST_PRINTED;
          end
        end
        OP_ADD, OP_SUB: begin
          if (s < 2) begin
            state_q[c] = RS_DONE;
            return ST_UNDERFLOW;
          end
          b = stack_mem[c][s-1];
          a = stack_mem[c][s-2];
          stack_mem[c][s-2] = (op == OP_ADD) ? a + b : a - b;
          s--;
        end
        OP_PAUSE: begin
          pc_q[c] = p;
          state_q[c] = RS_SUSPENDED;
          return ST_YIELDED;
        end
        OP_RET, OP_HALT: begin
          pc_q[c] = p;
          state_q[c] = RS_DONE;
          return ST_FINISHED;
        end
        default: p = (imm >= len) ? len : imm;
      endcase
      pc_q[c] = p;
      sp_q[c] = s;
      return ST_OK;
    endfunction

    // Note an accepted input transfer and queue its expected result.
    function void note_input(action_t act, int id, int addr, int data, int len);
      vm_result_t r;
      logic [WordW-1:0] shown;
      r = '0;
      r.st = ST_OK;
      case (act)
        ACT_LOAD: code_mem[id][addr] = data[7:0];
        ACT_CREATE: begin
          if (made >= 8) begin
            r.st = ST_FULL;
          end else begin
            state_q[made] = RS_READY;
            pc_q[made] = 0;
            sp_q[made] = 0;
            len_q[made] = (len > 256) ? 256 : len;
            for (int k = 0; k < 16; k++) local_mem[made][k] = '0;
            r.nid = made[IdW-1:0];
            made++;
            r.st = ST_CREATED;
          end
        end
        ACT_EXEC: begin
          if (id >= made) r.st = ST_BAD_ID;
          else if (state_q[id] == RS_DONE) r.st = ST_ALREADY;
          else begin
            r.st = step_context(id, shown);
            r.pv = shown;
          end
        end
        default: r.st = ST_OK;
      endcase
      pending_q.push_back(r);
    endfunction

    // Compare a result transfer with the oldest expectation.
    function void check_result(vm_result_t got);
      vm_result_t want;
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d value %0d id %0d",
                   got.st, $signed(got.pv), got.nid);
        return;
      end
      want = pending_q.pop_front();
      if (got.st !== want.st || got.pv !== want.pv || got.nid !== want.nid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d value %0d id %0d, got %0d %0d %0d",
                   want.st, $signed(want.pv), want.nid,
                   got.st, $signed(got.pv), got.nid);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [ActionW-1:0] action;
  logic [IdW-1:0]     context_id;
  logic [AddrW-1:0]   code_address;
  logic [ByteW-1:0]   code_byte;
  logic [LenW-1:0]    code_length;
  logic               out_valid;
  logic               out_stall;
  logic [StatusW-1:0] status;
  logic signed [WordW-1:0] printed_value;
  logic [IdW-1:0]     new_id;

  vm_scoreboard sb;
  bit           quiet;
  bit           idle_on;
  bit           loaded [8];
  logic [7:0]   prog [$];
  int           jmp_at2;

  coroutine_stack_vm_step dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .context_id(context_id), .code_address(code_address),
    .code_byte(code_byte), .code_length(code_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .printed_value(printed_value), .new_id(new_id)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 600000);
    $display("Some tests failed");
    $finish;
  end

  // Offer one item and wait for its transfer.
  task automatic send(action_t act, int id, int addr, int data, int len);
    if (idle_on && !quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    context_id   <= id[IdW-1:0];
    code_address <= addr[AddrW-1:0];
    code_byte    <= data[ByteW-1:0];
    code_length  <= len[LenW-1:0];
    do @(posedge clk); while (in_stall);
    sb.note_input(act, id, addr, data, len);
  endtask

  task automatic exec_ctx(int id);
    send(ACT_EXEC, id, $urandom_range(0, 255), $urandom_range(0, 255),
         $urandom_range(0, 511));
  endtask

  // Load the queued program bytes into context c.
  task automatic load_prog(int c);
    foreach (prog[i]) send(ACT_LOAD, c, i, prog[i], $urandom_range(0, 511));
    loaded[c] = 1;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void emit_wide(logic [7:0] op, logic [31:0] imm);
    prog.push_back(op);
    for (int k = 0; k < 4; k++) prog.push_back(imm[8*k +: 8]);
  endfunction

  // Build a stack-balanced looping program with random content.
  function automatic void build_loop();
    int blocks;
    int k;
    prog.delete();
    blocks = $urandom_range(3, 8);
    for (int n = 0; n < blocks; n++) begin
      k = $urandom_range(0, 15);
      case ($urandom_range(0, 4))
        0: begin
          emit_wide(OP_PUSH, pick_value());
          emit_wide(OP_PUSH, pick_value());
          prog.push_back($urandom_range(0, 1) ? OP_ADD : OP_SUB);
          prog.push_back(OP_EMIT);
        end
        1: begin
          emit_wide(OP_PUSH, pick_value());
          emit_wide(OP_STLOC, k);
          emit_wide(OP_LOAD, k);
          prog.push_back(OP_EMIT);
        end
        2: begin
          emit_wide(OP_PUSH, pick_value());
          prog.push_back(OP_POP);
        end
        3: prog.push_back(OP_PAUSE);
        default: begin
          emit_wide(OP_LOAD, k);
          emit_wide(OP_JZ, prog.size() + 5);
        end
      endcase
    end
    emit_wide(OP_JMP, 0);
  endfunction

  // Pick an execute target, favoring the overflow context while it lives.
  function automatic int pick_ctx();
    int c;
    if (sb.state_q[4] != RS_DONE && $urandom_range(0, 1) == 0) return 4;
    for (int tries = 0; tries < 8; tries++) begin
      c = $urandom_range(0, 7);
      if (loaded[c] && sb.state_q[c] != RS_DONE) return c;
    end
    return $urandom_range(0, 7);
  endfunction

  // Receiver: check transfers, stall in bursts, hold off once for long.
  initial begin
    bit long_done;
    long_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result('{status, printed_value, new_id});
      if (!long_done && sb.checked >= 300) begin
        long_done = 1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus.
  initial begin
    int wait_cycles;
    int r;
    sb = new();
    quiet = 0;
    idle_on = 1;
    foreach (loaded[c]) loaded[c] = 0;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    action       <= ACT_NONE;
    context_id   <= '0;
    code_address <= '0;
    code_byte    <= '0;
    code_length  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: uncreated id, no-op action, creates and the full table.
    exec_ctx(0);
    send(ACT_NONE, 7, 255, 255, 511);
    send(ACT_CREATE, 0, 0, 0, 0);
    send(ACT_CREATE, 0, 0, 0, 300);
    build_loop();
    for (int i = prog.size(); i < 256; i++) prog.push_back($urandom_range(0, 255));
    load_prog(1);
    build_loop();
    send(ACT_CREATE, 0, 0, 0, prog.size());
    jmp_at2 = prog.size() - 5;
    load_prog(2);
    build_loop();
    send(ACT_CREATE, 0, 0, 0, prog.size());
    load_prog(3);
    send(ACT_CREATE, 0, 0, 0, 10);
    send(ACT_CREATE, 0, 0, 0, 1);
    send(ACT_CREATE, 0, 0, 0, 3);
    send(ACT_CREATE, 0, 0, 0, 1);
    send(ACT_CREATE, 0, 0, 0, 256);
    prog.delete();
    emit_wide(OP_PUSH, $urandom);
    emit_wide(OP_JMP, 0);
    load_prog(4);
    prog = '{OP_POP};
    load_prog(5);
    prog = '{OP_PUSH, 8'h12, 8'h34};
    load_prog(6);
    prog = '{OP_CALL};
    load_prog(7);
    loaded[0] = 1;
    for (int c = 0; c < 8; c++) exec_ctx(c);
    exec_ctx(0);

    // Random: mostly executes of live contexts, some noise.
    for (int i = 0; i < 1240; i++) begin
      if (i % 200 == 0) idle_on = !idle_on;
      if (i == 1000) begin
        // Break the running programs: bad local, jump past the end, bad opcode.
        prog.delete();
        emit_wide(OP_LOAD, 32'h8000_0010);
        foreach (prog[j]) send(ACT_LOAD, 1, j, prog[j], $urandom_range(0, 511));
        for (int j = 1; j < 5; j++) send(ACT_LOAD, 2, jmp_at2 + j, 8'hFF, 0);
        send(ACT_LOAD, 3, 0, $urandom_range(13, 255), 0);
      end
      if (i == 1100) quiet = 1;
      r = $urandom_range(0, 99);
      if (r < 86) exec_ctx(pick_ctx());
      else if (r < 94)
        send(ACT_LOAD, 0, $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 511));
      else if (r < 97)
        send(ACT_NONE, $urandom_range(0, 7), $urandom_range(0, 255),
             $urandom_range(0, 255), $urandom_range(0, 511));
      else
        send(ACT_CREATE, $urandom_range(0, 7), $urandom_range(0, 255),
             $urandom_range(0, 255), $urandom_range(0, 511));
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then let the block settle.
    wait_cycles = 0;
    while (sb.pending_q.size() > 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/csvm_pkg.sv
rtl/core/csvm_code_mem.sv
rtl/core/csvm_word_mem.sv
rtl/core/coroutine_stack_vm_step.sv
dv/tb_coroutine_stack_vm_step.sv
